// ===== rtl/twa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the thermostat with window alarm.
// Used by every module of the block; depends on nothing.

package twa_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CMD_W       = 2;
    localparam int RESULT_W    = 11;
    localparam int OUT_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_TEMP    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STABLE_LOW     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STABLE_HIGH    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LOW      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_HIGH     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_HEAT_TIMEOUT   = 3'd6;

    // Command codes carried in tuser.
    localparam logic [CMD_W-1:0] CMD_SAMPLE     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK       = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR_REACH = 2'd2;

    // Reset values, in 1/16 degree units where they are temperatures.
    localparam int RST_TARGET_TEMP  = 592;
    localparam int RST_STABLE_LOW   = 560;
    localparam int RST_STABLE_HIGH  = 688;
    localparam int RST_RANGE_LOW    = 528;
    localparam int RST_RANGE_HIGH   = 688;
    localparam int RST_HEAT_TIMEOUT = 600000;
    localparam int RST_LAST_TEMP    = -16;

    // One result item; the last member sits in bit 0.
    typedef struct packed {
        logic cancel_tests_pulse;
        logic finalize_pulse;
        logic enable_ui_pulse;
        logic status_blink;
        logic ready_for_samples;
        logic in_range;
        logic is_stabilized;
        logic target_reached;
        logic timeout_error;
        logic alarm_active;
        logic heater_drive;
    } result_t;

endpackage

// ===== rtl/twa_cfg.sv =====
`timescale 1ns / 1ps
// Configuration registers of the thermostat with window alarm.
// Depends on twa_pkg for register indexes and reset values.

module twa_cfg
    import twa_pkg::*;
#(
    parameter int TEMP_WIDTH  = 12,
    parameter int TIMER_WIDTH = 24,
    parameter int DATA_W      = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [DATA_W-1:0]             cfg_data,
    output logic                          control_enable,
    output logic signed [TEMP_WIDTH-1:0]  target_temp,
    output logic signed [TEMP_WIDTH-1:0]  stable_low,
    output logic signed [TEMP_WIDTH-1:0]  stable_high,
    output logic signed [TEMP_WIDTH-1:0]  range_low,
    output logic signed [TEMP_WIDTH-1:0]  range_high,
    output logic [TIMER_WIDTH-1:0]        heat_timeout,
    output logic                          heater_kill
);

    logic                         control_enable_reg;
    logic signed [TEMP_WIDTH-1:0] target_temp_reg;
    logic signed [TEMP_WIDTH-1:0] stable_low_reg;
    logic signed [TEMP_WIDTH-1:0] stable_high_reg;
    logic signed [TEMP_WIDTH-1:0] range_low_reg;
    logic signed [TEMP_WIDTH-1:0] range_high_reg;
    logic [TIMER_WIDTH-1:0]       heat_timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_enable_reg <= 1'b1;
            target_temp_reg    <= TEMP_WIDTH'(RST_TARGET_TEMP);
            stable_low_reg     <= TEMP_WIDTH'(RST_STABLE_LOW);
            stable_high_reg    <= TEMP_WIDTH'(RST_STABLE_HIGH);
            range_low_reg      <= TEMP_WIDTH'(RST_RANGE_LOW);
            range_high_reg     <= TEMP_WIDTH'(RST_RANGE_HIGH);
            heat_timeout_reg   <= TIMER_WIDTH'(RST_HEAT_TIMEOUT);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CONTROL_ENABLE: control_enable_reg <= cfg_data[0];
                REG_TARGET_TEMP:    target_temp_reg    <= cfg_data[TEMP_WIDTH-1:0];
                REG_STABLE_LOW:     stable_low_reg     <= cfg_data[TEMP_WIDTH-1:0];
                REG_STABLE_HIGH:    stable_high_reg    <= cfg_data[TEMP_WIDTH-1:0];
                REG_RANGE_LOW:      range_low_reg      <= cfg_data[TEMP_WIDTH-1:0];
                REG_RANGE_HIGH:     range_high_reg     <= cfg_data[TEMP_WIDTH-1:0];
                REG_HEAT_TIMEOUT:   heat_timeout_reg   <= cfg_data[TIMER_WIDTH-1:0];
                default:            ;
            endcase
        end
    end

    // Disabling control turns the heater off and stops the timeout.
    assign heater_kill = cfg_wr_en && (cfg_index == REG_CONTROL_ENABLE) && !cfg_data[0];

    assign control_enable = control_enable_reg;
    assign target_temp    = target_temp_reg;
    assign stable_low     = stable_low_reg;
    assign stable_high    = stable_high_reg;
    assign range_low      = range_low_reg;
    assign range_high     = range_high_reg;
    assign heat_timeout   = heat_timeout_reg;

endmodule

// ===== rtl/twa_ctrl.sv =====
`timescale 1ns / 1ps
// Thermostat state, heating timeout and window comparators.
// Depends on twa_pkg; computes the next state and the result of one item.

module twa_ctrl
    import twa_pkg::*;
#(
    parameter int TEMP_WIDTH  = 12,
    parameter int TIMER_WIDTH = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [CMD_W-1:0]              command,
    input  logic signed [TEMP_WIDTH-1:0]  temperature,
    input  logic                          testing_active,
    input  logic                          control_enable,
    input  logic signed [TEMP_WIDTH-1:0]  target_temp,
    input  logic signed [TEMP_WIDTH-1:0]  stable_low,
    input  logic signed [TEMP_WIDTH-1:0]  stable_high,
    input  logic signed [TEMP_WIDTH-1:0]  range_low,
    input  logic signed [TEMP_WIDTH-1:0]  range_high,
    input  logic [TIMER_WIDTH-1:0]        heat_timeout,
    input  logic                          heater_kill,
    output result_t                       result
);

    logic signed [TEMP_WIDTH-1:0] last_temp_reg, last_temp_next;
    logic                         heater_reg, heater_next;
    logic                         running_reg, running_next;
    logic [TIMER_WIDTH-1:0]       count_reg, count_next;
    logic                         reached_reg, reached_next;
    logic                         pending_reg, pending_next;
    logic                         cancelled_reg, cancelled_next;
    logic                         alarm_reg, alarm_next;
    logic                         timeout_reg, timeout_next;
    logic                         blink_reg, blink_next;
    logic                         ui_pulse, fin_pulse, cancel_pulse;
    logic                         stab, inr;

    // In a sample the new last temperature is the sample, so one pair of
    // window comparators serves both the state update and the result.
    always_comb
    begin
        last_temp_next = last_temp_reg;
        if (command == CMD_SAMPLE)
        begin
            last_temp_next = temperature;
        end
        stab = (last_temp_next >= stable_low) && (last_temp_next <= stable_high);
        inr  = (last_temp_next >= range_low) && (last_temp_next <= range_high);
    end

    always_comb
    begin
        heater_next    = heater_reg;
        running_next   = running_reg;
        count_next     = count_reg;
        reached_next   = reached_reg;
        pending_next   = pending_reg;
        cancelled_next = cancelled_reg;
        alarm_next     = alarm_reg;
        timeout_next   = timeout_reg;
        blink_next     = blink_reg;
        ui_pulse       = 1'b0;
        fin_pulse      = 1'b0;
        cancel_pulse   = 1'b0;

        unique case (command)
            CMD_SAMPLE:
            begin
                if (temperature >= target_temp)
                begin
                    reached_next = 1'b1;
                end
                if (control_enable)
                begin
                    if (temperature < target_temp)
                    begin
                        heater_next = 1'b1;
                        if (!running_reg)
                        begin
                            running_next = 1'b1;
                            count_next   = heat_timeout;
                        end
                    end
                    else
                    begin
                        heater_next  = 1'b0;
                        running_next = 1'b0;
                    end
                end
                if (stab)
                begin
                    if (pending_reg)
                    begin
                        ui_pulse     = 1'b1;
                        pending_next = 1'b0;
                        fin_pulse    = !testing_active;
                    end
                    alarm_next = 1'b0;
                    blink_next = 1'b0;
                end
                else if (inr)
                begin
                    alarm_next     = 1'b0;
                    cancelled_next = 1'b0;
                    blink_next     = 1'b0;
                end
                else
                begin
                    blink_next = 1'b1;
                    if (!cancelled_reg && testing_active)
                    begin
                        cancelled_next = 1'b1;
                        cancel_pulse   = 1'b1;
                    end
                    if ((temperature > range_high) ||
                        (!pending_reg && (temperature < range_low)))
                    begin
                        alarm_next = 1'b1;
                    end
                end
            end
            CMD_TICK:
            begin
                if (running_reg)
                begin
                    // A count of zero or one expires on this tick.
                    if (count_reg <= TIMER_WIDTH'(1))
                    begin
                        count_next   = '0;
                        timeout_next = 1'b1;
                        heater_next  = 1'b0;
                        running_next = 1'b0;
                        alarm_next   = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg - TIMER_WIDTH'(1);
                    end
                end
            end
            CMD_CLEAR_REACH:
            begin
                reached_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_temp_reg <= TEMP_WIDTH'(RST_LAST_TEMP);
            heater_reg    <= 1'b0;
            running_reg   <= 1'b0;
            count_reg     <= '0;
            reached_reg   <= 1'b0;
            pending_reg   <= 1'b1;
            cancelled_reg <= 1'b0;
            alarm_reg     <= 1'b0;
            timeout_reg   <= 1'b0;
            blink_reg     <= 1'b0;
        end
        else if (accept)
        begin
            last_temp_reg <= last_temp_next;
            heater_reg    <= heater_next;
            running_reg   <= running_next;
            count_reg     <= count_next;
            reached_reg   <= reached_next;
            pending_reg   <= pending_next;
            cancelled_reg <= cancelled_next;
            alarm_reg     <= alarm_next;
            timeout_reg   <= timeout_next;
            blink_reg     <= blink_next;
        end
        else if (heater_kill)
        begin
            heater_reg  <= 1'b0;
            running_reg <= 1'b0;
        end
    end

    always_comb
    begin
        result.heater_drive       = heater_next;
        result.alarm_active       = alarm_next;
        result.timeout_error      = timeout_next;
        result.target_reached     = reached_next;
        result.is_stabilized      = stab;
        result.in_range           = inr;
        result.ready_for_samples  = reached_next && inr;
        result.status_blink       = blink_next;
        result.enable_ui_pulse    = ui_pulse;
        result.finalize_pulse     = fin_pulse;
        result.cancel_tests_pulse = cancel_pulse;
    end

endmodule

// ===== rtl/twa_out.sv =====
`timescale 1ns / 1ps
// Result register of the thermostat with window alarm.
// Depends on twa_pkg for the result type; holds one result until transfer.

module twa_out
    import twa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result_in,
    input  logic    out_ready,
    output logic    space,
    output logic    out_valid,
    output result_t result_out
);

    logic    valid_reg;
    result_t result_reg;

    // A new result may enter while the held one leaves in the same cycle.
    assign space = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (space)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

// ===== rtl/thermostat_with_window_alarm.sv =====
`timescale 1ns / 1ps
// On/off heater thermostat with heating timeout and window alarms.
// Depends on twa_pkg, twa_cfg, twa_ctrl and twa_out.
//
// Use: each transfer on the slave stream is one command, chosen by s_axis_tuser:
// a temperature sample, a timer tick or a clear of the reached-target latch.
// Each command gives exactly one status item on the master stream.
// The configuration port writes one register per cycle in which cfg_wr_en is
// high; write it only while no status item is outstanding.
// Latency: the status item is valid the cycle after the command transfer.
// Throughput: one command per clock unless the receiver stalls; state update and
// window comparators settle between the command transfer and the status register.
// Reset clears the state, loads the default setpoints and windows, and empties
// the status register. When the receiver stalls, the one held status item stays
// put and s_axis_tready falls until it is taken; a new command is taken in the
// same cycle in which the held item transfers.

module thermostat_with_window_alarm
    import twa_pkg::*;
#(
    parameter int TEMP_WIDTH  = 12,
    parameter int TIMER_WIDTH = 24
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Slave stream, tuser: command[1:0].
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: temperature[TEMP_WIDTH-1:0], testing_active, zero fill.
    input  logic [((TEMP_WIDTH + 1 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic [CMD_W-1:0]                      s_axis_tuser,
    // Master stream, tdata: heater_drive, alarm_active, timeout_error,
    // target_reached, is_stabilized, in_range, ready_for_samples,
    // status_blink, enable_ui_pulse, finalize_pulse, cancel_tests_pulse, zero fill.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]                 m_axis_tdata,
    // Configuration write port.
    input  logic                                  cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]                cfg_index,
    input  logic [((TIMER_WIDTH > TEMP_WIDTH) ? TIMER_WIDTH : TEMP_WIDTH)-1:0] cfg_data
);

    localparam int DATA_W = (TIMER_WIDTH > TEMP_WIDTH) ? TIMER_WIDTH : TEMP_WIDTH;

    logic                         control_enable;
    logic signed [TEMP_WIDTH-1:0] target_temp;
    logic signed [TEMP_WIDTH-1:0] stable_low;
    logic signed [TEMP_WIDTH-1:0] stable_high;
    logic signed [TEMP_WIDTH-1:0] range_low;
    logic signed [TEMP_WIDTH-1:0] range_high;
    logic [TIMER_WIDTH-1:0]       heat_timeout;
    logic                         heater_kill;
    logic                         space;
    logic                         accept;
    result_t                      result_next;
    result_t                      result_held;

    assign s_axis_tready = space;
    assign accept        = s_axis_tvalid && space;

    twa_cfg #(
        .TEMP_WIDTH  (TEMP_WIDTH),
        .TIMER_WIDTH (TIMER_WIDTH),
        .DATA_W      (DATA_W)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .control_enable (control_enable),
        .target_temp    (target_temp),
        .stable_low     (stable_low),
        .stable_high    (stable_high),
        .range_low      (range_low),
        .range_high     (range_high),
        .heat_timeout   (heat_timeout),
        .heater_kill    (heater_kill)
    );

    twa_ctrl #(
        .TEMP_WIDTH  (TEMP_WIDTH),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .command        (s_axis_tuser),
        .temperature    (s_axis_tdata[TEMP_WIDTH-1:0]),
        .testing_active (s_axis_tdata[TEMP_WIDTH]),
        .control_enable (control_enable),
        .target_temp    (target_temp),
        .stable_low     (stable_low),
        .stable_high    (stable_high),
        .range_low      (range_low),
        .range_high     (range_high),
        .heat_timeout   (heat_timeout),
        .heater_kill    (heater_kill),
        .result         (result_next)
    );

    twa_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .result_in  (result_next),
        .out_ready  (m_axis_tready),
        .space      (space),
        .out_valid  (m_axis_tvalid),
        .result_out (result_held)
    );

    assign m_axis_tdata = {(OUT_DATA_W - RESULT_W)'(0), result_held};

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for thermostat_with_window_alarm: directed and random
// commands, random stalls on both streams, checked against a local thermostat predictor.
// Depends on twa_pkg and the thermostat_with_window_alarm RTL.

module testbench;
    import twa_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int QUIET_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 10;
    localparam int LONG_STALL   = 90;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 50;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic signed [11:0] temp;
        logic               testing;
    } cmd_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [CMD_W-1:0] s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [23:0] cfg_data = '0;

    // Predictor copy of the registers.
    logic               cfg_enable;
    logic signed [11:0] cfg_target, cfg_stab_lo, cfg_stab_hi, cfg_rng_lo, cfg_rng_hi;
    logic [23:0]        cfg_timeout;

    // Predictor copy of the thermostat state.
    logic signed [11:0] last_temp;
    logic               heater_level, timer_active, reached, first_stable_wait;
    logic               tests_cancelled, alarm, timeout_err, blink;
    logic [23:0]        timer_left;

    cmd_item_t pending_cmds[$];
    result_t   status_expected[$];
    int        items_queued = 0;
    int        items_accepted = 0;
    int        mismatches = 0;
    int        quiet_cycles = 0;
    logic      in_taken = 1'b0;
    logic      no_idle = 1'b0;
    logic      hold_off_req = 1'b0;
    logic      hold_off_done = 1'b0;
    int        stall_left = 0;

    thermostat_with_window_alarm u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic string field_label(input int bit_pos);
        case (bit_pos)
            0:       return "heater_drive";
            1:       return "alarm_active";
            2:       return "timeout_error";
            3:       return "target_reached";
            4:       return "is_stabilized";
            5:       return "in_range";
            6:       return "ready_for_samples";
            7:       return "status_blink";
            8:       return "enable_ui_pulse";
            9:       return "finalize_pulse";
            default: return "cancel_tests_pulse";
        endcase
    endfunction

    // Applies one command to the predicted thermostat state and returns the status.
    task automatic advance_thermostat(input logic [CMD_W-1:0] cmd,
                                      input logic signed [11:0] t,
                                      input logic testing,
                                      output result_t status);
        logic stab, inr;
        logic ui_pulse, fin_pulse, cancel_pulse;
        ui_pulse = 1'b0;
        fin_pulse = 1'b0;
        cancel_pulse = 1'b0;
        case (cmd)
            CMD_SAMPLE:
            begin
                last_temp = t;
                if (t >= cfg_target)
                    reached = 1'b1;
                if (cfg_enable)
                begin
                    if (t < cfg_target)
                    begin
                        heater_level = 1'b1;
                        // A running timeout is never restarted.
                        if (!timer_active)
                        begin
                            timer_active = 1'b1;
                            timer_left = cfg_timeout;
                        end
                    end
                    else
                    begin
                        heater_level = 1'b0;
                        timer_active = 1'b0;
                    end
                end
                stab = (t >= cfg_stab_lo) && (t <= cfg_stab_hi);
                inr = (t >= cfg_rng_lo) && (t <= cfg_rng_hi);
                if (stab)
                begin
                    if (first_stable_wait)
                    begin
                        ui_pulse = 1'b1;
                        first_stable_wait = 1'b0;
                        fin_pulse = !testing;
                    end
                    alarm = 1'b0;
                    blink = 1'b0;
                end
                else if (inr)
                begin
                    alarm = 1'b0;
                    tests_cancelled = 1'b0;
                    blink = 1'b0;
                end
                else
                begin
                    blink = 1'b1;
                    if (!tests_cancelled && testing)
                    begin
                        tests_cancelled = 1'b1;
                        cancel_pulse = 1'b1;
                    end
                    // Below the range only alarms once the block has stabilized.
                    if (t > cfg_rng_hi || (!first_stable_wait && t < cfg_rng_lo))
                        alarm = 1'b1;
                end
            end
            CMD_TICK:
            begin
                if (timer_active)
                begin
                    // A zero timeout behaves as one tick.
                    if (timer_left <= 24'd1)
                    begin
                        timer_left = '0;
                        timeout_err = 1'b1;
                        heater_level = 1'b0;
                        timer_active = 1'b0;
                        alarm = 1'b1;
                    end
                    else
                        timer_left = timer_left - 24'd1;
                end
            end
            CMD_CLEAR_REACH:
                reached = 1'b0;
            default:
                ;
        endcase
        stab = (last_temp >= cfg_stab_lo) && (last_temp <= cfg_stab_hi);
        inr = (last_temp >= cfg_rng_lo) && (last_temp <= cfg_rng_hi);
        status = '0;
        status.heater_drive       = heater_level;
        status.alarm_active       = alarm;
        status.timeout_error      = timeout_err;
        status.target_reached     = reached;
        status.is_stabilized      = stab;
        status.in_range           = inr;
        status.ready_for_samples  = reached && inr;
        status.status_blink       = blink;
        status.enable_ui_pulse    = ui_pulse;
        status.finalize_pulse     = fin_pulse;
        status.cancel_tests_pulse = cancel_pulse;
    endtask

    // Sender: offers queued commands, holding each until its transfer.
    always @(negedge clk)
    begin : cmd_driver
        cmd_item_t it;
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (pending_cmds.size() > 0 && (no_idle || $urandom_range(99) >= 33))
            begin
                it = pending_cmds.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {3'b000, it.testing, it.temp};
                s_axis_tuser  <= it.cmd;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver pacing, with one long hold-off so the block backs up.
    always @(negedge clk)
    begin : status_sink
        if (hold_off_req && !hold_off_done)
        begin
            stall_left = LONG_STALL;
            hold_off_done = 1'b1;
        end
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (no_idle)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= 33);
    end

    // Checks status transfers, then predicts for command transfers; also the watchdog.
    always @(posedge clk)
    begin : status_monitor
        result_t seen, want, predicted;
        logic in_xfer, out_xfer;
        if (rst_n)
        begin
            in_xfer = s_axis_tvalid && s_axis_tready;
            out_xfer = m_axis_tvalid && m_axis_tready;
            if (out_xfer)
            begin
                seen = result_t'(m_axis_tdata[RESULT_W-1:0]);
                if (status_expected.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: status transfer with none expected: %b", $realtime, seen);
                end
                else
                begin
                    want = status_expected.pop_front();
                    for (int i = 0; i < RESULT_W; i++)
                    begin
                        if (seen[i] !== want[i])
                        begin
                            mismatches = mismatches + 1;
                            if (mismatches <= MAX_REPORTS)
                                $display("%0t: %s expected %b, got %b", $realtime,
                                         field_label(i), want[i], seen[i]);
                        end
                    end
                end
            end
            if (in_xfer)
            begin
                advance_thermostat(s_axis_tuser, $signed(s_axis_tdata[11:0]),
                                   s_axis_tdata[12], predicted);
                status_expected.push_back(predicted);
                items_accepted = items_accepted + 1;
            end
            in_taken <= in_xfer;
            if (in_xfer || out_xfer)
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int temp,
                             input logic testing);
        cmd_item_t it;
        it.cmd = cmd;
        it.temp = temp[11:0];
        it.testing = testing;
        pending_cmds.push_back(it);
        items_queued = items_queued + 1;
    endtask

    // Returns at a falling edge once every command has transferred and been answered.
    task automatic wait_idle();
        while (items_accepted != items_queued || status_expected.size() != 0)
            @(negedge clk);
    endtask

    // Called at a falling edge; leaves the write enable high for a following write.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [23:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_CONTROL_ENABLE:
            begin
                cfg_enable = val[0];
                if (!val[0])
                begin
                    heater_level = 1'b0;
                    timer_active = 1'b0;
                end
            end
            REG_TARGET_TEMP:  cfg_target = $signed(val[11:0]);
            REG_STABLE_LOW:   cfg_stab_lo = $signed(val[11:0]);
            REG_STABLE_HIGH:  cfg_stab_hi = $signed(val[11:0]);
            REG_RANGE_LOW:    cfg_rng_lo = $signed(val[11:0]);
            REG_RANGE_HIGH:   cfg_rng_hi = $signed(val[11:0]);
            REG_HEAT_TIMEOUT: cfg_timeout = val;
            default:          ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic ena, input int tgt, input int sl, input int sh,
                                  input int rl, input int rh, input int tmo);
        write_register(REG_CONTROL_ENABLE, {23'd0, ena});
        write_register(REG_TARGET_TEMP, {12'd0, tgt[11:0]});
        write_register(REG_STABLE_LOW, {12'd0, sl[11:0]});
        write_register(REG_STABLE_HIGH, {12'd0, sh[11:0]});
        write_register(REG_RANGE_LOW, {12'd0, rl[11:0]});
        write_register(REG_RANGE_HIGH, {12'd0, rh[11:0]});
        write_register(REG_HEAT_TIMEOUT, tmo[23:0]);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin : stimulus
        int pick, base, v, lo1, hi1, lo2, hi2, tmo;
        logic [CMD_W-1:0] cmd;

        cfg_enable   = 1'b1;
        cfg_target   = RST_TARGET_TEMP[11:0];
        cfg_stab_lo  = RST_STABLE_LOW[11:0];
        cfg_stab_hi  = RST_STABLE_HIGH[11:0];
        cfg_rng_lo   = RST_RANGE_LOW[11:0];
        cfg_rng_hi   = RST_RANGE_HIGH[11:0];
        cfg_timeout  = RST_HEAT_TIMEOUT[23:0];
        last_temp    = RST_LAST_TEMP[11:0];
        heater_level = 1'b0;
        timer_active = 1'b0;
        timer_left   = '0;
        reached      = 1'b0;
        first_stable_wait = 1'b1;
        tests_cancelled = 1'b0;
        alarm        = 1'b0;
        timeout_err  = 1'b0;
        blink        = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: status at reset, idle tick, window and range edges.
        queue_cmd(CMD_UNUSED, 0, 1'b1);
        queue_cmd(CMD_TICK, 0, 1'b0);
        queue_cmd(CMD_SAMPLE, 2047, 1'b1);
        queue_cmd(CMD_SAMPLE, 2047, 1'b1);
        queue_cmd(CMD_SAMPLE, -2048, 1'b0);
        queue_cmd(CMD_SAMPLE, 600, 1'b0);
        queue_cmd(CMD_SAMPLE, 591, 1'b1);
        queue_cmd(CMD_SAMPLE, 592, 1'b0);
        queue_cmd(CMD_CLEAR_REACH, 0, 1'b0);
        queue_cmd(CMD_SAMPLE, 540, 1'b1);
        queue_cmd(CMD_SAMPLE, 527, 1'b1);
        queue_cmd(CMD_SAMPLE, 528, 1'b0);
        queue_cmd(CMD_SAMPLE, 688, 1'b1);
        queue_cmd(CMD_SAMPLE, 689, 1'b0);
        queue_cmd(CMD_TICK, 0, 1'b1);
        wait_idle();

        // Short timeout: the timer is not restarted and then expires.
        apply_settings(1'b1, 100, 50, 150, 0, 200, 3);
        queue_cmd(CMD_SAMPLE, 20, 1'b0);
        queue_cmd(CMD_SAMPLE, 30, 1'b1);
        queue_cmd(CMD_TICK, 0, 1'b0);
        queue_cmd(CMD_TICK, 0, 1'b0);
        queue_cmd(CMD_TICK, 0, 1'b0);
        queue_cmd(CMD_TICK, 0, 1'b0);
        queue_cmd(CMD_SAMPLE, 120, 1'b0);
        wait_idle();

        // Zero timeout expires on the first tick.
        apply_settings(1'b1, 100, 50, 150, 0, 200, 0);
        queue_cmd(CMD_SAMPLE, 20, 1'b0);
        queue_cmd(CMD_TICK, 0, 1'b0);
        queue_cmd(CMD_SAMPLE, 20, 1'b0);
        wait_idle();

        // Disabling control while heating turns the heater off.
        write_register(REG_CONTROL_ENABLE, 24'd0);
        cfg_wr_en <= 1'b0;
        queue_cmd(CMD_SAMPLE, 20, 1'b1);
        queue_cmd(CMD_TICK, 0, 1'b0);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0: apply_settings(1'b1, -2048, -2048, 2047, -2048, 2047, 24'hFFFFFF);
                // Both windows inverted, so neither can be satisfied.
                1: apply_settings(1'b1, 2047, 2047, -2048, 2047, -2048, 1);
                default:
                begin
                    lo1 = $urandom_range(4095) - 2048;
                    hi1 = lo1 + $urandom_range(300);
                    lo2 = lo1 - $urandom_range(100);
                    hi2 = hi1 + $urandom_range(100);
                    if ($urandom_range(7) == 0)
                    begin
                        v = lo1;
                        lo1 = hi1;
                        hi1 = v;
                    end
                    if ($urandom_range(7) == 0)
                    begin
                        v = lo2;
                        lo2 = hi2 + 1;
                        hi2 = v;
                    end
                    tmo = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
                    apply_settings(($urandom_range(4) != 0), lo1 + $urandom_range(300),
                                   lo1, hi1, lo2, hi2, tmo);
                end
            endcase
            if (p == 3)
            begin
                no_idle = 1'b1;
                hold_off_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 45)
                    cmd = CMD_SAMPLE;
                else if (pick < 85)
                    cmd = CMD_TICK;
                else if (pick < 95)
                    cmd = CMD_CLEAR_REACH;
                else
                    cmd = CMD_UNUSED;
                // Mostly land near a threshold so every comparator edge is hit.
                case ($urandom_range(5))
                    0: base = cfg_target;
                    1: base = cfg_stab_lo;
                    2: base = cfg_stab_hi;
                    3: base = cfg_rng_lo;
                    4: base = cfg_rng_hi;
                    default: base = $urandom_range(4095);
                endcase
                v = base + $urandom_range(6) - 3;
                queue_cmd(cmd, v, $urandom_range(1));
            end
            wait_idle();
            no_idle = 1'b0;
        end

        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
